[rtl/core/lij_pkg.sv]
`timescale 1ns / 1ps
// Shared types and widths for the line intersection / jacobian unit.
// No dependencies; used by lij_div and line_intersection_jacobian_unit.
package lij_pkg;

  localparam int CW   = 18;  // input coordinate
  localparam int EW   = 19;  // coordinate difference
  localparam int PW   = 38;  // product of two differences
  localparam int VW   = 39;  // den, nn, aa
  localparam int WW   = 40;  // derivative weight
  localparam int MW   = 40;  // magnitude operand of the split multiplier
  localparam int HW   = 20;  // half of MW
  localparam int MULW = 80;  // full MW x MW product
  localparam int TW   = 59;  // point numerator p*den + e*nn
  localparam int QW   = 32;  // result width
  localparam int OPW  = 4;

  localparam logic [QW-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [QW-1:0] SAT_NEG = 32'h8000_0000;

  typedef enum logic [OPW-1:0] {
    OP_POINT = 4'd0,
    OP_X1    = 4'd1,
    OP_Y1    = 4'd2,
    OP_X2    = 4'd3,
    OP_Y2    = 4'd4,
    OP_X3    = 4'd5,
    OP_Y3    = 4'd6,
    OP_X4    = 4'd7,
    OP_Y4    = 4'd8
  } lij_op_e;

  // flags that ride along with the divider lanes
  typedef struct packed {
    logic       deg;
    logic       zero;
    logic [1:0] neg;
  } lij_side_t;

endpackage

[rtl/core/lij_div.sv]
`timescale 1ns / 1ps
// Two-lane pipelined restoring divider, one quotient bit per stage.
// Depends on lij_pkg for QW and lij_side_t.
module lij_div import lij_pkg::*; #(
  parameter int NW = 98,
  parameter int DW = 81
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [1:0][NW-1:0]    num_i,
  input  logic [DW-1:0]         den_i,
  input  lij_side_t             side_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [1:0][QW-1:0]    quot_o,
  output logic [1:0]            ovf_o,
  output lij_side_t             side_o
);

  localparam int RW = DW + QW;

  logic [QW:0]    v_q;
  logic [QW:0]    v_d;
  logic [QW:0]    en;

  logic [RW-1:0]  rem_q  [QW][2];
  logic [DW-1:0]  den_q  [QW];
  logic [QW-1:0]  quo_q  [QW+1][2];
  logic           ovf_q  [QW+1][2];
  lij_side_t      side_q [QW+1];

  // a stage loads when empty or when the next one moves
  assign en[QW] = !v_q[QW] | ready_i;
  for (genvar j = 0; j < QW; j++) begin : g_en
    assign en[j] = !v_q[j] | en[j+1];
  end
  assign ready_o = en[0];
  assign v_d     = {v_q[QW-1:0], valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int j = 0; j <= QW; j++) begin
        if (en[j]) begin
          v_q[j] <= v_d[j];
        end
      end
    end
  end

  // stage 0: a quotient of 2^QW or more sets the overflow flag
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int i = 0; i < 2; i++) begin
        rem_q[0][i] <= RW'(num_i[i]);
        quo_q[0][i] <= '0;
        ovf_q[0][i] <= RW'(num_i[i]) >= (RW'(den_i) << QW);
      end
      den_q[0]  <= den_i;
      side_q[0] <= side_i;
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_step
    localparam int K = QW - j;
    logic [RW-1:0] sh;
    logic [1:0]    ge;

    assign sh    = RW'(den_q[j-1]) << K;
    assign ge[0] = rem_q[j-1][0] >= sh;
    assign ge[1] = rem_q[j-1][1] >= sh;

    always_ff @(posedge clk_i) begin
      if (en[j]) begin
        for (int i = 0; i < 2; i++) begin
          quo_q[j][i] <= quo_q[j-1][i] | (QW'(ge[i]) << K);
          ovf_q[j][i] <= ovf_q[j-1][i];
        end
        side_q[j] <= side_q[j-1];
      end
    end

    if (j < QW) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en[j]) begin
          for (int i = 0; i < 2; i++) begin
            rem_q[j][i] <= ge[i] ? rem_q[j-1][i] - sh : rem_q[j-1][i];
          end
          den_q[j] <= den_q[j-1];
        end
      end
    end
  end

  assign valid_o   = v_q[QW];
  assign quot_o[0] = quo_q[QW][0];
  assign quot_o[1] = quo_q[QW][1];
  assign ovf_o[0]  = ovf_q[QW][0];
  assign ovf_o[1]  = ovf_q[QW][1];
  assign side_o    = side_q[QW];

endmodule

[rtl/core/line_intersection_jacobian_unit.sv]
`timescale 1ns / 1ps
// Top level: line intersection point and its partial derivatives.
// Depends on lij_pkg and lij_div.

// Takes one beat per clock unless stalled and returns one result beat per input beat,
// in order: 8 front stages form the cross products, the numerators and the
// denominator (D for the point, D^2 for a derivative) with 20x20 partial products,
// 33 divider stages resolve an overflow check and one quotient bit each, and one
// stage applies the sign, saturates and registers the result. Results are rounded to
// nearest, ties away from zero. Parallel lines set degenerate and return zeros; opcodes
// above 8 return zeros. Backpressure fills pipeline bubbles before it stalls the input.
module line_intersection_jacobian_unit import lij_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [OPW-1:0]       opcode_i,
  input  logic signed [CW-1:0] ax_i,
  input  logic signed [CW-1:0] ay_i,
  input  logic signed [CW-1:0] bx_i,
  input  logic signed [CW-1:0] by_coord_i,
  input  logic signed [CW-1:0] cx_i,
  input  logic signed [CW-1:0] cy_i,
  input  logic signed [CW-1:0] dx_i,
  input  logic signed [CW-1:0] dy_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [QW-1:0] out_x_o,
  output logic signed [QW-1:0] out_y_o,
  output logic                 degenerate_o,
  output logic                 saturated_o
);

  localparam int NW = MULW + FRAC_BITS + 2;
  localparam int DW = MULW + 1;

  logic [8:1] v_q, v_d, en;
  logic       div_rdy;

  always_comb begin
    en[8] = !v_q[8] | div_rdy;
    for (int k = 1; k < 8; k++) begin
      en[k] = !v_q[k] | en[k+1];
    end
  end
  assign in_ready_o = en[1];
  assign v_d        = {v_q[7:1], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 1; k <= 8; k++) begin
        if (en[k]) begin
          v_q[k] <= v_d[k];
        end
      end
    end
  end

  // stage 1: differences
  logic signed [EW-1:0] s1_ex_q, s1_ey_q, s1_fx_q, s1_fy_q, s1_ux_q, s1_uy_q;
  logic signed [CW-1:0] s1_p_q [2];
  lij_op_e              s1_op_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_ex_q   <= EW'(bx_i) - EW'(ax_i);
      s1_ey_q   <= EW'(by_coord_i) - EW'(ay_i);
      s1_fx_q   <= EW'(dx_i) - EW'(cx_i);
      s1_fy_q   <= EW'(dy_i) - EW'(cy_i);
      s1_ux_q   <= EW'(cx_i) - EW'(ax_i);
      s1_uy_q   <= EW'(cy_i) - EW'(ay_i);
      s1_p_q[0] <= ax_i;
      s1_p_q[1] <= ay_i;
      s1_op_q   <= lij_op_e'(opcode_i);
    end
  end

  // stage 2: cross products
  logic signed [PW-1:0] s2_exfy_q, s2_eyfx_q, s2_eyfy_q, s2_exfx_q;
  logic signed [PW-1:0] s2_uxfy_q, s2_uyfx_q, s2_uxey_q, s2_uyex_q;
  logic signed [EW-1:0] s2_e_q [2];
  logic signed [CW-1:0] s2_p_q [2];
  lij_op_e              s2_op_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s2_exfy_q <= s1_ex_q * s1_fy_q;
      s2_eyfx_q <= s1_ey_q * s1_fx_q;
      s2_eyfy_q <= s1_ey_q * s1_fy_q;
      s2_exfx_q <= s1_ex_q * s1_fx_q;
      s2_uxfy_q <= s1_ux_q * s1_fy_q;
      s2_uyfx_q <= s1_uy_q * s1_fx_q;
      s2_uxey_q <= s1_ux_q * s1_ey_q;
      s2_uyex_q <= s1_uy_q * s1_ex_q;
      s2_e_q[0] <= s1_ex_q;
      s2_e_q[1] <= s1_ey_q;
      s2_p_q    <= s1_p_q;
      s2_op_q   <= s1_op_q;
    end
  end

  // stage 3: den, nn, aa and the direction factor of each lane
  logic signed [PW-1:0] dk_c [2];

  always_comb begin
    dk_c[0] = '0;
    dk_c[1] = '0;
    case (s2_op_q)
      OP_X1: begin dk_c[0] = s2_eyfx_q;  dk_c[1] = s2_eyfy_q;  end
      OP_Y1: begin dk_c[0] = s2_exfx_q;  dk_c[1] = s2_exfy_q;  end
      OP_X2: begin dk_c[0] = -s2_eyfx_q; dk_c[1] = -s2_eyfy_q; end
      OP_Y2: begin dk_c[0] = s2_exfx_q;  dk_c[1] = s2_exfy_q;  end
      OP_X3: begin dk_c[0] = s2_exfy_q;  dk_c[1] = s2_eyfy_q;  end
      OP_Y3: begin dk_c[0] = s2_exfx_q;  dk_c[1] = s2_eyfx_q;  end
      OP_X4: begin dk_c[0] = s2_exfy_q;  dk_c[1] = s2_eyfy_q;  end
      OP_Y4: begin dk_c[0] = -s2_exfx_q; dk_c[1] = -s2_eyfx_q; end
      default: ;
    endcase
  end

  logic signed [VW-1:0] s3_den_q, s3_nn_q, s3_aa_q;
  logic signed [PW-1:0] s3_dk_q [2];
  logic signed [EW-1:0] s3_e_q  [2];
  logic signed [CW-1:0] s3_p_q  [2];
  lij_op_e              s3_op_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s3_den_q <= VW'(s2_exfy_q) - VW'(s2_eyfx_q);
      s3_nn_q  <= VW'(s2_uxfy_q) - VW'(s2_uyfx_q);
      s3_aa_q  <= VW'(s2_uxey_q) - VW'(s2_uyex_q);
      s3_dk_q  <= dk_c;
      s3_e_q   <= s2_e_q;
      s3_p_q   <= s2_p_q;
      s3_op_q  <= s2_op_q;
    end
  end

  // stage 4: weight term and magnitudes
  logic signed [WW-1:0] w_c;
  logic signed [MW-1:0] den_x_c;
  logic signed [MW-1:0] dk_x_c [2];

  always_comb begin
    w_c = '0;
    case (s3_op_q)
      OP_X1:        w_c = WW'(s3_nn_q) - WW'(s3_den_q);
      OP_Y1:        w_c = WW'(s3_den_q) - WW'(s3_nn_q);
      OP_X2, OP_Y2: w_c = WW'(s3_nn_q);
      OP_X3:        w_c = WW'(s3_den_q) - WW'(s3_aa_q);
      OP_Y3:        w_c = WW'(s3_aa_q) - WW'(s3_den_q);
      OP_X4, OP_Y4: w_c = WW'(s3_aa_q);
      default: ;
    endcase
    den_x_c   = MW'(s3_den_q);
    dk_x_c[0] = MW'(s3_dk_q[0]);
    dk_x_c[1] = MW'(s3_dk_q[1]);
  end

  logic signed [WW-1:0] s4_w_q;
  logic        [MW-1:0] s4_denm_q;
  logic        [MW-1:0] s4_dkm_q [2];
  logic                 s4_dkn_q [2];
  logic signed [VW-1:0] s4_den_q, s4_nn_q;
  logic signed [EW-1:0] s4_e_q [2];
  logic signed [CW-1:0] s4_p_q [2];
  logic                 s4_pt_q, s4_deg_q, s4_zero_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s4_w_q    <= w_c;
      s4_denm_q <= den_x_c[MW-1] ? -den_x_c : den_x_c;
      for (int i = 0; i < 2; i++) begin
        s4_dkm_q[i] <= dk_x_c[i][MW-1] ? -dk_x_c[i] : dk_x_c[i];
        s4_dkn_q[i] <= dk_x_c[i][MW-1];
      end
      s4_den_q  <= s3_den_q;
      s4_nn_q   <= s3_nn_q;
      s4_e_q    <= s3_e_q;
      s4_p_q    <= s3_p_q;
      s4_pt_q   <= s3_op_q == OP_POINT;
      s4_deg_q  <= s3_den_q == '0;
      s4_zero_q <= (s3_den_q == '0) || !(s3_op_q inside {[OP_POINT:OP_Y4]});
    end
  end

  // stage 5: |w|, point partial products, D^2 partial products
  logic signed [HW-2:0] denh_c, nnh_c;
  logic signed [HW:0]   denl_c, nnl_c;

  assign denh_c = $signed(s4_den_q[VW-1:HW]);
  assign nnh_c  = $signed(s4_nn_q[VW-1:HW]);
  assign denl_c = $signed({1'b0, s4_den_q[HW-1:0]});
  assign nnl_c  = $signed({1'b0, s4_nn_q[HW-1:0]});

  logic        [MW-1:0] s5_wm_q, s5_denm_q;
  logic        [MW-1:0] s5_dkm_q [2];
  logic                 s5_dn_q  [2];
  logic signed [TW-1:0] s5_ph_q [2], s5_pl_q [2], s5_eh_q [2], s5_el_q [2];
  logic        [MW-1:0] s5_ddll_q, s5_ddlh_q, s5_ddhh_q;
  logic                 s5_denneg_q, s5_pt_q, s5_deg_q, s5_zero_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s5_wm_q <= s4_w_q[WW-1] ? MW'(-s4_w_q) : MW'(s4_w_q);
      for (int i = 0; i < 2; i++) begin
        s5_dn_q[i] <= s4_dkn_q[i] ^ s4_w_q[WW-1];
        s5_ph_q[i] <= TW'(s4_p_q[i]) * TW'(denh_c);
        s5_pl_q[i] <= TW'(s4_p_q[i]) * TW'(denl_c);
        s5_eh_q[i] <= TW'(s4_e_q[i]) * TW'(nnh_c);
        s5_el_q[i] <= TW'(s4_e_q[i]) * TW'(nnl_c);
      end
      s5_ddll_q   <= MW'(s4_denm_q[HW-1:0]) * MW'(s4_denm_q[HW-1:0]);
      s5_ddlh_q   <= MW'(s4_denm_q[HW-1:0]) * MW'(s4_denm_q[MW-1:HW]);
      s5_ddhh_q   <= MW'(s4_denm_q[MW-1:HW]) * MW'(s4_denm_q[MW-1:HW]);
      s5_dkm_q    <= s4_dkm_q;
      s5_denm_q   <= s4_denm_q;
      s5_denneg_q <= s4_den_q[VW-1];
      s5_pt_q     <= s4_pt_q;
      s5_deg_q    <= s4_deg_q;
      s5_zero_q   <= s4_zero_q;
    end
  end

  // stage 6: derivative partial products, D^2 and point numerator sums
  logic        [MW-1:0]   s6_ll_q [2], s6_lh_q [2], s6_hl_q [2], s6_hh_q [2];
  logic        [MULW-1:0] s6_dd_q;
  logic signed [TW-1:0]   s6_t_q [2];
  logic        [MW-1:0]   s6_denm_q;
  logic                   s6_dn_q [2];
  logic                   s6_denneg_q, s6_pt_q, s6_deg_q, s6_zero_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      for (int i = 0; i < 2; i++) begin
        s6_ll_q[i] <= MW'(s5_dkm_q[i][HW-1:0]) * MW'(s5_wm_q[HW-1:0]);
        s6_lh_q[i] <= MW'(s5_dkm_q[i][HW-1:0]) * MW'(s5_wm_q[MW-1:HW]);
        s6_hl_q[i] <= MW'(s5_dkm_q[i][MW-1:HW]) * MW'(s5_wm_q[HW-1:0]);
        s6_hh_q[i] <= MW'(s5_dkm_q[i][MW-1:HW]) * MW'(s5_wm_q[MW-1:HW]);
        s6_t_q[i]  <= (s5_ph_q[i] <<< HW) + s5_pl_q[i] + (s5_eh_q[i] <<< HW) + s5_el_q[i];
      end
      // cross term appears twice in the square
      s6_dd_q     <= (MULW'(s5_ddhh_q) << MW) + (MULW'(s5_ddlh_q) << (HW + 1))
                     + MULW'(s5_ddll_q);
      s6_denm_q   <= s5_denm_q;
      s6_dn_q     <= s5_dn_q;
      s6_denneg_q <= s5_denneg_q;
      s6_pt_q     <= s5_pt_q;
      s6_deg_q    <= s5_deg_q;
      s6_zero_q   <= s5_zero_q;
    end
  end

  // stage 7: derivative numerators, point magnitudes
  logic [MULW-1:0] s7_num_q [2];
  logic [TW-1:0]   s7_tm_q  [2];
  logic            s7_tn_q  [2];
  logic            s7_dn_q  [2];
  logic [MULW-1:0] s7_dd_q;
  logic [MW-1:0]   s7_denm_q;
  logic            s7_pt_q, s7_deg_q, s7_zero_q;

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      for (int i = 0; i < 2; i++) begin
        s7_num_q[i] <= (MULW'(s6_hh_q[i]) << MW)
                       + ((MULW'(s6_lh_q[i]) + MULW'(s6_hl_q[i])) << HW)
                       + MULW'(s6_ll_q[i]);
        s7_tm_q[i]  <= s6_t_q[i][TW-1] ? TW'(-s6_t_q[i]) : TW'(s6_t_q[i]);
        s7_tn_q[i]  <= s6_t_q[i][TW-1] ^ s6_denneg_q;
      end
      s7_dn_q   <= s6_dn_q;
      s7_dd_q   <= s6_dd_q;
      s7_denm_q <= s6_denm_q;
      s7_pt_q   <= s6_pt_q;
      s7_deg_q  <= s6_deg_q;
      s7_zero_q <= s6_zero_q;
    end
  end

  // stage 8: rounding operands 2n + d over 2d
  logic [1:0][NW-1:0] s8_n_q;
  logic [DW-1:0]      s8_d_q;
  lij_side_t          s8_side_q;

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      for (int i = 0; i < 2; i++) begin
        if (s7_pt_q) begin
          s8_n_q[i]         <= NW'({s7_tm_q[i], 1'b0}) + NW'(s7_denm_q);
          s8_side_q.neg[i]  <= s7_tn_q[i];
        end else begin
          s8_n_q[i]         <= (NW'(s7_num_q[i]) << (FRAC_BITS + 1)) + NW'(s7_dd_q);
          s8_side_q.neg[i]  <= s7_dn_q[i];
        end
      end
      s8_d_q         <= s7_pt_q ? (DW'(s7_denm_q) << 1) : (DW'(s7_dd_q) << 1);
      s8_side_q.deg  <= s7_deg_q;
      s8_side_q.zero <= s7_zero_q;
    end
  end

  logic               dv_valid;
  logic               o_en;
  logic [1:0][QW-1:0] dv_quot;
  logic [1:0]         dv_ovf;
  lij_side_t          dv_side;

  lij_div #(
    .NW (NW),
    .DW (DW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v_q[8]),
    .ready_o (div_rdy),
    .num_i   (s8_n_q),
    .den_i   (s8_d_q),
    .side_i  (s8_side_q),
    .valid_o (dv_valid),
    .ready_i (o_en),
    .quot_o  (dv_quot),
    .ovf_o   (dv_ovf),
    .side_o  (dv_side)
  );

  // output stage: sign, clamp, zero for parallel lines or unused opcodes
  logic              o_v_q;
  logic [QW-1:0]     res_c [2];
  logic [1:0]        big_c;
  logic [QW-1:0]     o_x_q, o_y_q;
  logic              o_deg_q, o_sat_q;

  assign o_en = !o_v_q | out_ready_i;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      big_c[i] = dv_ovf[i] | (dv_quot[i][QW-1] & (!dv_side.neg[i] | (dv_quot[i][QW-2:0] != '0)));
      if (dv_side.zero) begin
        res_c[i] = '0;
      end else if (big_c[i]) begin
        res_c[i] = dv_side.neg[i] ? SAT_NEG : SAT_POS;
      end else begin
        res_c[i] = dv_side.neg[i] ? -dv_quot[i] : dv_quot[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else if (o_en) begin
      o_v_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_en) begin
      o_x_q   <= res_c[0];
      o_y_q   <= res_c[1];
      o_deg_q <= dv_side.deg;
      o_sat_q <= !dv_side.zero & (big_c[0] | big_c[1]);
    end
  end

  assign out_valid_o  = o_v_q;
  assign out_x_o      = o_x_q;
  assign out_y_o      = o_y_q;
  assign degenerate_o = o_deg_q;
  assign saturated_o  = o_sat_q;

endmodule

[sim/lij_result_monitor.sv]
`timescale 1ns / 1ps
// Watches both channels of the line intersection / jacobian unit, predicts each result
// and compares it with the output beat. Depends on lij_pkg.
module lij_result_monitor import lij_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [OPW-1:0]       opcode_i,
  input  logic signed [CW-1:0] ax_i,
  input  logic signed [CW-1:0] ay_i,
  input  logic signed [CW-1:0] bx_i,
  input  logic signed [CW-1:0] by_coord_i,
  input  logic signed [CW-1:0] cx_i,
  input  logic signed [CW-1:0] cy_i,
  input  logic signed [CW-1:0] dx_i,
  input  logic signed [CW-1:0] dy_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic signed [QW-1:0] out_x_i,
  input  logic signed [QW-1:0] out_y_i,
  input  logic                 degenerate_i,
  input  logic                 saturated_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  typedef struct {
    logic [QW-1:0] x;
    logic [QW-1:0] y;
    logic          deg;
    logic          sat;
  } lij_result_t;

  lij_result_t pending_q[$];

  function automatic logic [127:0] mag128(longint v);
    return (v < 0) ? 128'(-v) : 128'(v);
  endfunction

  // round |num|/|den| to nearest, ties away from zero, then clamp
  function automatic bit round_clamp(logic [127:0] num, logic [127:0] den, bit neg,
                                     output logic [QW-1:0] v);
    logic [127:0] q;
    logic [127:0] lim;
    q   = ((num << 1) + den) / (den << 1);
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (q > lim) begin
      v = neg ? SAT_NEG : SAT_POS;
      return 1'b1;
    end
    v = neg ? -q[QW-1:0] : q[QW-1:0];
    return 1'b0;
  endfunction

  function automatic bit partial(longint dir, longint k, longint w, longint den,
                                 output logic [QW-1:0] v);
    longint dk;
    bit     neg;
    dk  = dir * k;
    neg = ((dk < 0) != (w < 0)) && dk != 0 && w != 0;
    return round_clamp((mag128(dk) * mag128(w)) << FRAC_BITS, mag128(den) * mag128(den),
                       neg, v);
  endfunction

  function automatic bit cross_point(longint p, longint e, longint n, longint den,
                                     output logic [QW-1:0] v);
    longint t;
    bit     neg;
    t   = p * den + e * n;
    neg = ((t < 0) != (den < 0)) && t != 0;
    return round_clamp(mag128(t), mag128(den), neg, v);
  endfunction

  function automatic lij_result_t predict_intersection(logic [OPW-1:0] op,
      longint x1, longint y1, longint x2, longint y2,
      longint x3, longint y3, longint x4, longint y4);
    lij_result_t r;
    longint ex, ey, fx, fy, ux, uy, den, nn, aa;
    bit s;
    ex = x2 - x1; ey = y2 - y1; fx = x4 - x3; fy = y4 - y3;
    ux = x3 - x1; uy = y3 - y1;
    den = ex * fy - ey * fx;
    nn  = ux * fy - uy * fx;
    aa  = ux * ey - uy * ex;
    r.x = '0; r.y = '0; s = 1'b0;
    r.deg = (den == 0);
    if (den != 0) begin
      case (op)
        OP_POINT: begin
          s = cross_point(x1, ex, nn, den, r.x);
          s |= cross_point(y1, ey, nn, den, r.y);
        end
        OP_X1: begin
          s = partial(fx, ey, nn - den, den, r.x);
          s |= partial(fy, ey, nn - den, den, r.y);
        end
        OP_Y1: begin
          s = partial(fx, ex, den - nn, den, r.x);
          s |= partial(fy, ex, den - nn, den, r.y);
        end
        OP_X2: begin
          s = partial(fx, -ey, nn, den, r.x);
          s |= partial(fy, -ey, nn, den, r.y);
        end
        OP_Y2: begin
          s = partial(fx, ex, nn, den, r.x);
          s |= partial(fy, ex, nn, den, r.y);
        end
        OP_X3: begin
          s = partial(ex, fy, den - aa, den, r.x);
          s |= partial(ey, fy, den - aa, den, r.y);
        end
        OP_Y3: begin
          s = partial(ex, fx, aa - den, den, r.x);
          s |= partial(ey, fx, aa - den, den, r.y);
        end
        OP_X4: begin
          s = partial(ex, fy, aa, den, r.x);
          s |= partial(ey, fy, aa, den, r.y);
        end
        OP_Y4: begin
          s = partial(ex, -fx, aa, den, r.x);
          s |= partial(ey, -fx, aa, den, r.y);
        end
        default: ;
      endcase
    end
    r.sat = s;
    return r;
  endfunction

  initial fail_count_o = 0;
  assign pending_o = pending_q.size();

  always @(posedge clk_i) begin
    lij_result_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i)
        pending_q.push_back(predict_intersection(opcode_i, ax_i, ay_i, bx_i, by_coord_i,
                                                 cx_i, cy_i, dx_i, dy_i));
      if (out_valid_i && out_ready_i) begin
        if (pending_q.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count_o++;
        end else begin
          want = pending_q.pop_front();
          if (out_x_i !== want.x) begin
            $error("out_x expected %0d actual %0d", $signed(want.x), out_x_i);
            fail_count_o++;
          end
          if (out_y_i !== want.y) begin
            $error("out_y expected %0d actual %0d", $signed(want.y), out_y_i);
            fail_count_o++;
          end
          if (degenerate_i !== want.deg) begin
            $error("degenerate expected %0b actual %0b", want.deg, degenerate_i);
            fail_count_o++;
          end
          if (saturated_i !== want.sat) begin
            $error("saturated expected %0b actual %0b", want.sat, saturated_i);
            fail_count_o++;
          end
        end
      end
    end
  end

endmodule

[sim/line_intersection_jacobian_unit_test.sv]
`timescale 1ns / 1ps
// Stimulus and verdict for line_intersection_jacobian_unit.
// Depends on lij_pkg, the unit itself and lij_result_monitor.
module line_intersection_jacobian_unit_test;
  import lij_pkg::*;

  localparam int CMAX = 131071;
  localparam int CMIN = -131072;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OPW-1:0] opcode = '0;
  logic signed [CW-1:0] ax = '0, ay = '0, bx = '0, by_c = '0;
  logic signed [CW-1:0] cx = '0, cy = '0, dx = '0, dy = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [QW-1:0] out_x, out_y;
  logic degenerate, saturated;
  int fail_count, pending;
  int hold_req = 0;
  int burst_left = 0;

  always #5 clk = ~clk;

  line_intersection_jacobian_unit dut (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_ready_o(in_ready),
    .opcode_i(opcode), .ax_i(ax), .ay_i(ay), .bx_i(bx), .by_coord_i(by_c),
    .cx_i(cx), .cy_i(cy), .dx_i(dx), .dy_i(dy), .out_valid_o(out_valid),
    .out_ready_i(out_ready), .out_x_o(out_x), .out_y_o(out_y),
    .degenerate_o(degenerate), .saturated_o(saturated)
  );

  lij_result_monitor mon (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_ready_i(in_ready),
    .opcode_i(opcode), .ax_i(ax), .ay_i(ay), .bx_i(bx), .by_coord_i(by_c),
    .cx_i(cx), .cy_i(cy), .dx_i(dx), .dy_i(dy), .out_valid_i(out_valid),
    .out_ready_i(out_ready), .out_x_i(out_x), .out_y_i(out_y),
    .degenerate_i(degenerate), .saturated_i(saturated),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver: stall pattern redrawn each time the phase counter wraps, long hold-off on request
  initial begin
    int hold_cnt, hold_seen, mode, phase;
    hold_cnt = 0; hold_seen = 0; mode = 0; phase = 0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_cnt  = 300;
      end
      if (phase == 0) mode = $urandom_range(3);
      phase = (phase + 1) % 64;
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= $urandom_range(1);
          2: out_ready <= ($urandom_range(9) != 0);
          default: out_ready <= (phase % 8) < 3;
        endcase
      end
    end
  end

  function automatic logic signed [CW-1:0] clip(longint v);
    return (v > CMAX) ? CW'(CMAX) : (v < CMIN) ? CW'(CMIN) : CW'(v);
  endfunction

  // one beat; valid stays up across a burst, then a random gap, possibly none
  task automatic send_beat(logic [OPW-1:0] op, longint p[8]);
    int gap;
    @(negedge clk);
    opcode <= op;
    ax <= clip(p[0]); ay <= clip(p[1]); bx <= clip(p[2]); by_c <= clip(p[3]);
    cx <= clip(p[4]); cy <= clip(p[5]); dx <= clip(p[6]); dy <= clip(p[7]);
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(20);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  function automatic longint rand_coord(int scale);
    case (scale)
      0: return longint'($urandom_range(262143)) - 131072;
      1: return longint'($urandom_range(8191)) - 4096;
      default: return ($urandom_range(1) == 1) ? CMAX : CMIN;
    endcase
  endfunction

  initial begin
    longint p[8];
    longint kx, ky;
    int sc, kind;
    logic [OPW-1:0] op;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // every opcode, unused ones too, on a plain crossing
    for (int i = 0; i < 16; i++) begin
      p = '{0, 0, 65536, 65536, 0, 65536, 65536, 0};
      send_beat(OPW'(i), p);
    end
    // full-scale corners, parallel, coincident, nearly parallel, all points equal
    p = '{CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN};
    send_beat(OP_POINT, p);
    send_beat(OP_X1, p);
    p = '{CMAX, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN};
    send_beat(OP_Y4, p);
    p = '{0, 0, 65536, 0, 0, 65536, 65536, 65536};
    send_beat(OP_POINT, p);
    p = '{0, 0, 65536, 65536, 131071, 131071, -131072, -131072};
    send_beat(OP_X3, p);
    p = '{CMIN, CMIN, CMAX, CMAX, CMIN, CMIN + 1, CMAX, CMAX};
    send_beat(OP_POINT, p);
    send_beat(OP_Y2, p);
    p = '{1, 0, 0, 1, 0, 0, 1, 1};
    send_beat(OP_X4, p);
    p = '{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX};
    send_beat(OP_Y3, p);

    for (int n = 0; n < 1300; n++) begin
      if (n == 400) hold_req++;
      if (n == 800) begin
        // drop valid so the last beat is not offered again while draining
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
      end
      kind = $urandom_range(9);
      op   = (kind == 0) ? OPW'($urandom_range(15, 9)) : OPW'($urandom_range(8));
      sc   = ($urandom_range(7) == 0) ? 2 : $urandom_range(1);
      foreach (p[i]) p[i] = rand_coord(sc);
      if (kind == 1 || kind == 2) begin
        // second line parallel to the first up to rounding, or off by a small step
        kx = longint'($urandom_range(4)) - 2;
        if (kx == 0) kx = 1;
        p[6] = p[4] + kx * (p[2] - p[0]) / 2;
        p[7] = p[5] + kx * (p[3] - p[1]) / 2;
        if (kind == 2) begin
          kx = longint'($urandom_range(6)) - 3;
          ky = longint'($urandom_range(6)) - 3;
          p[6] += kx;
          p[7] += ky;
        end
      end
      send_beat(op, p);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    wait (pending == 0);
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
